[rtl/hmt_pkg.sv]
package hmt_pkg;

   // Field widths
   localparam int TEMP_W  = 12;
   localparam int STAMP_W = 32;
   localparam int MS_W    = 16;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 16;
   localparam int CMP_W   = TEMP_W + 2;

   // Machine modes
   typedef enum logic [2:0] {
      MODE_INIT  = 3'd0,
      MODE_COLD  = 3'd1,
      MODE_NEAR  = 3'd2,
      MODE_SET   = 3'd3,
      MODE_BREW  = 3'd4,
      MODE_AFTER = 3'd5,
      MODE_STEAM = 3'd6,
      MODE_CHILL = 3'd7
   } mode_type;

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_TARGET_TEMP   = 3'd0,
      CSR_STEAM_TEMP    = 3'd1,
      CSR_COLD_MARGIN   = 3'd2,
      CSR_HOLD_MS       = 3'd3,
      CSR_BREW_LIMIT_MS = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [TEMP_W-1:0] TARGET_TEMP_RST   = 12'd1488;
   localparam logic [TEMP_W-1:0] STEAM_TEMP_RST    = 12'd1840;
   localparam logic [TEMP_W-1:0] COLD_MARGIN_RST   = 12'd160;
   localparam logic [MS_W-1:0]   HOLD_MS_RST       = 16'd10000;
   localparam logic [MS_W-1:0]   BREW_LIMIT_MS_RST = 16'd35000;

   // Temperature bands, sixteenths of a degree
   localparam logic signed [CMP_W-1:0] NEAR_BAND    = 14'sd16;
   localparam logic signed [CMP_W-1:0] CHILL_BAND   = 14'sd32;
   localparam logic signed [CMP_W-1:0] COLD_CEILING = 14'sd2400;

   typedef struct packed {
      logic [TEMP_W-1:0] target_temp;
      logic [TEMP_W-1:0] steam_temp;
      logic [TEMP_W-1:0] cold_margin;
      logic [MS_W-1:0]   hold_ms;
      logic [MS_W-1:0]   brew_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  temperature;
      logic [STAMP_W-1:0] now_ms;
      logic               brew_detected;
      logic [MS_W-1:0]    brew_time_ms;
      logic               heat_rate_rising;
   } req_item_type;

   // Outcome of one tick for the state registers
   typedef struct packed {
      mode_type mode;
      logic     cold_waiting;
      logic     load_stamp;
   } step_type;

endpackage

[rtl/hmt_req_if.sv]
interface hmt_req_if import hmt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TEMP_W-1:0]  temperature;
   logic [STAMP_W-1:0] now_ms;
   logic               brew_detected;
   logic [MS_W-1:0]    brew_time_ms;
   logic               heat_rate_rising;

   modport source (output valid, temperature, now_ms, brew_detected, brew_time_ms,
                   heat_rate_rising, input ready);
   modport sink (input valid, temperature, now_ms, brew_detected, brew_time_ms,
                 heat_rate_rising, output ready);
endinterface

[rtl/hmt_rsp_if.sv]
interface hmt_rsp_if import hmt_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] machine_mode;

   modport source (output valid, machine_mode, input ready);
   modport sink (input valid, machine_mode, output ready);
endinterface

[rtl/hmt_csr_if.sv]
interface hmt_csr_if import hmt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/hmt_csr.sv]
module hmt_csr import hmt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hmt_csr_if.sink    csr_ch,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TARGET_TEMP:   cfg_in.target_temp   = csr_ch.data[TEMP_W-1:0];
            CSR_STEAM_TEMP:    cfg_in.steam_temp    = csr_ch.data[TEMP_W-1:0];
            CSR_COLD_MARGIN:   cfg_in.cold_margin   = csr_ch.data[TEMP_W-1:0];
            CSR_HOLD_MS:       cfg_in.hold_ms       = csr_ch.data[MS_W-1:0];
            CSR_BREW_LIMIT_MS: cfg_in.brew_limit_ms = csr_ch.data[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp   <= TARGET_TEMP_RST;
         cfg_ff.steam_temp    <= STEAM_TEMP_RST;
         cfg_ff.cold_margin   <= COLD_MARGIN_RST;
         cfg_ff.hold_ms       <= HOLD_MS_RST;
         cfg_ff.brew_limit_ms <= BREW_LIMIT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/hmt_next_mode.sv]
module hmt_next_mode import hmt_pkg::*; (
   input  req_item_type       item,
   input  cfg_type            cfg,
   input  mode_type           mode,
   input  logic               cold_waiting,
   input  logic [STAMP_W-1:0] cold_start_stamp,
   output step_type           step
);

   logic signed [CMP_W-1:0] t_s;
   logic signed [CMP_W-1:0] tgt_s;
   logic signed [CMP_W-1:0] steam_s;
   logic signed [CMP_W-1:0] cold_thr;
   logic signed [CMP_W-1:0] near_thr;
   logic signed [CMP_W-1:0] chill_thr;
   logic [STAMP_W-1:0]      deadline;
   logic                    is_steam;
   logic                    brew_active;
   logic                    timed_out;

   // Temperatures widened to signed so thresholds below zero compare correctly
   assign t_s       = $signed({2'b00, item.temperature});
   assign tgt_s     = $signed({2'b00, cfg.target_temp});
   assign steam_s   = $signed({2'b00, cfg.steam_temp});
   assign cold_thr  = tgt_s - $signed({2'b00, cfg.cold_margin});
   assign near_thr  = tgt_s - NEAR_BAND;
   assign chill_thr = tgt_s + CHILL_BAND;

   assign is_steam    = t_s >= steam_s;
   assign brew_active = item.brew_time_ms != '0;

   // Hold timer, wraps modulo 2^32
   assign deadline  = cold_start_stamp + {{(STAMP_W-MS_W){1'b0}}, cfg.hold_ms};
   assign timed_out = deadline < item.now_ms;

   // Mode transitions; outside init, steam override applied last
   always_comb begin
      step.mode         = mode;
      step.cold_waiting = cold_waiting;
      step.load_stamp   = 1'b0;
      unique case (mode)
         MODE_INIT: begin
            if (t_s < cold_thr)
               step.mode = MODE_COLD;
            else if (is_steam)
               step.mode = MODE_STEAM;
            else
               step.mode = MODE_SET;
         end
         MODE_COLD: begin
            if (!cold_waiting) begin
               if (t_s >= near_thr && t_s < COLD_CEILING) begin
                  step.load_stamp   = 1'b1;
                  step.cold_waiting = 1'b1;
               end
            end else begin
               if (t_s < near_thr)
                  step.cold_waiting = 1'b0;
               if (timed_out)
                  step.mode = MODE_NEAR;
            end
            if (brew_active) step.mode = MODE_BREW;
            if (is_steam) step.mode = MODE_STEAM;
         end
         MODE_NEAR: begin
            if (t_s >= tgt_s) step.mode = MODE_SET;
            if (brew_active) step.mode = MODE_BREW;
            if (is_steam) step.mode = MODE_STEAM;
         end
         MODE_SET: begin
            if (brew_active) step.mode = MODE_BREW;
            if (is_steam) step.mode = MODE_STEAM;
         end
         MODE_BREW: begin
            if (!item.brew_detected)
               step.mode = MODE_SET;
            else if (item.brew_time_ms > cfg.brew_limit_ms)
               step.mode = MODE_AFTER;
            if (is_steam) step.mode = MODE_STEAM;
         end
         MODE_AFTER: begin
            step.mode = item.brew_detected ? MODE_BREW : MODE_SET;
            if (is_steam) step.mode = MODE_STEAM;
         end
         MODE_STEAM: begin
            if (!is_steam) step.mode = MODE_CHILL;
         end
         MODE_CHILL: begin
            if (item.heat_rate_rising && t_s < chill_thr) step.mode = MODE_SET;
            if (is_steam) step.mode = MODE_STEAM;
         end
         default: step.mode = mode;
      endcase
   end

endmodule

[rtl/heater_mode_tracker.sv]
// Boiler machine-mode tracker. Each request is one evaluation tick (temperature,
// timestamp, brew flag, brew time, heat-rate sign) and yields one response with
// the machine mode after that tick. A request is captured in an input register
// and the mode update moves it into the response register once that is free or
// being drained, so one request is taken every cycle while the response side
// keeps up; a stalled response holds the input register, which still takes one
// further request. Registers are written over the csr channel, which is always
// ready, and should only be written while no tick is in flight.
module heater_mode_tracker import hmt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   hmt_req_if.sink  req_ch,
   hmt_rsp_if.source rsp_ch,
   hmt_csr_if.sink  csr_ch
);

   cfg_type            cfg;
   step_type           step;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   req_item_type       s1_item_ff;
   logic               res_valid_ff;
   logic               res_valid_in;
   mode_type           res_mode_ff;
   mode_type           mode_ff;
   logic               waiting_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic               advance;
   logic               take_req;

   hmt_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   hmt_next_mode u_next (
      .item             (s1_item_ff),
      .cfg              (cfg),
      .mode             (mode_ff),
      .cold_waiting     (waiting_ff),
      .cold_start_stamp (stamp_ff),
      .step             (step)
   );

   // Handshake: tick moves on when the response slot is free or being drained
   assign advance      = s1_valid_ff && (!res_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign take_req     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign res_valid_in = advance || (res_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid        = res_valid_ff;
   assign rsp_ch.machine_mode = res_mode_ff;

   // Control and mode state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         mode_ff      <= MODE_INIT;
         waiting_ff   <= 1'b0;
         stamp_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         res_valid_ff <= res_valid_in;
         if (advance) begin
            mode_ff    <= step.mode;
            waiting_ff <= step.cold_waiting;
            if (step.load_stamp)
               stamp_ff <= s1_item_ff.now_ms;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_item_ff.temperature      <= req_ch.temperature;
         s1_item_ff.now_ms           <= req_ch.now_ms;
         s1_item_ff.brew_detected    <= req_ch.brew_detected;
         s1_item_ff.brew_time_ms     <= req_ch.brew_time_ms;
         s1_item_ff.heat_rate_rising <= req_ch.heat_rate_rising;
      end
      if (advance)
         res_mode_ff <= step.mode;
   end

   // Checks
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> res_mode_ff == mode_ff)
      else $error("response mode differs from tracked mode");

   a_wait_only_in_cold: assert property (@(posedge clock) disable iff (reset)
      $rose(waiting_ff) |-> $past(mode_ff) == MODE_COLD)
      else $error("cold hold started outside cold mode");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> res_valid_ff)
      else $error("tick advanced without a response");

endmodule

[tb/heater_mode_tracker_tb.sv]
module heater_mode_tracker_tb;
   import hmt_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SHOWN_ERRORS = 10;

   logic clock;
   logic reset;

   hmt_req_if req_bus ();
   hmt_rsp_if rsp_bus ();
   hmt_csr_if csr_bus ();

   heater_mode_tracker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Requests waiting to be sent and modes waiting to come back
   req_item_type pending_ticks[$];
   mode_type     expected_modes[$];

   // Shadow of the tracker: registers and state
   cfg_type            model_cfg;
   mode_type           track_mode;
   logic               track_waiting;
   logic [STAMP_W-1:0] track_stamp;

   bit                 idle_on;
   int                 fail_count;
   int                 cycle_count;
   int                 send_gap;
   int                 stall_left;
   logic [STAMP_W-1:0] stamp_ms;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("heater_mode_tracker_tb failed");
         $finish;
      end
   end

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= SHOWN_ERRORS) $display("ERROR: %s", what);
   endfunction

   // Mostly short gaps, now and then a long one; none while idling is switched off
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TEMP_W-1:0] clamp_temp(input int v);
      if (v < 0) return '0;
      if (v > (1 << TEMP_W) - 1) return '1;
      return TEMP_W'(v);
   endfunction

   function automatic req_item_type make_tick(input logic [TEMP_W-1:0] temp,
                                              input logic [STAMP_W-1:0] now,
                                              input logic det,
                                              input logic [MS_W-1:0] btime,
                                              input logic rising);
      req_item_type tick;
      tick.temperature      = temp;
      tick.now_ms           = now;
      tick.brew_detected    = det;
      tick.brew_time_ms     = btime;
      tick.heat_rate_rising = rising;
      return tick;
   endfunction

   function automatic logic [STAMP_W-1:0] next_stamp();
      stamp_ms += $urandom_range(0, 1500);
      return stamp_ms;
   endfunction

   // Temperatures biased towards the thresholds of the current setting
   function automatic logic [TEMP_W-1:0] pick_temp();
      int tgt;
      int stm;
      tgt = int'(model_cfg.target_temp);
      stm = int'(model_cfg.steam_temp);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? '1 : '0;
         1, 2, 3: return clamp_temp(tgt + int'($urandom_range(0, 80)) - 40);
         4, 5: return clamp_temp(stm + int'($urandom_range(0, 16)) - 8);
         6: return clamp_temp(tgt + int'(CHILL_BAND) + int'($urandom_range(0, 6)) - 3);
         7: return clamp_temp(tgt - int'(NEAR_BAND) + int'($urandom_range(0, 6)) - 3);
         default: return TEMP_W'($urandom_range(0, (1 << TEMP_W) - 1));
      endcase
   endfunction

   // Mode update for one tick
   function automatic mode_type advance_mode(input req_item_type tick);
      int                 temp_i;
      int                 tgt_i;
      logic               is_steam;
      logic               has_brew;
      logic [STAMP_W-1:0] deadline;
      temp_i   = int'(tick.temperature);
      tgt_i    = int'(model_cfg.target_temp);
      is_steam = temp_i >= int'(model_cfg.steam_temp);
      has_brew = tick.brew_time_ms != '0;
      case (track_mode)
         MODE_INIT: begin
            if (temp_i < tgt_i - int'(model_cfg.cold_margin)) track_mode = MODE_COLD;
            else if (is_steam) track_mode = MODE_STEAM;
            else track_mode = MODE_SET;
         end
         MODE_COLD: begin
            if (!track_waiting) begin
               if (temp_i >= tgt_i - int'(NEAR_BAND) && temp_i < int'(COLD_CEILING)) begin
                  track_stamp   = tick.now_ms;
                  track_waiting = 1'b1;
               end
            end else begin
               if (temp_i < tgt_i - int'(NEAR_BAND)) track_waiting = 1'b0;
               // timeout still uses the old stamp; the sum wraps at 32 bits
               deadline = track_stamp + STAMP_W'(model_cfg.hold_ms);
               if (deadline < tick.now_ms) track_mode = MODE_NEAR;
            end
            if (has_brew) track_mode = MODE_BREW;
            if (is_steam) track_mode = MODE_STEAM;
         end
         MODE_NEAR: begin
            if (temp_i >= tgt_i) track_mode = MODE_SET;
            if (has_brew) track_mode = MODE_BREW;
            if (is_steam) track_mode = MODE_STEAM;
         end
         MODE_SET: begin
            if (has_brew) track_mode = MODE_BREW;
            if (is_steam) track_mode = MODE_STEAM;
         end
         MODE_BREW: begin
            if (!tick.brew_detected) track_mode = MODE_SET;
            else if (tick.brew_time_ms > model_cfg.brew_limit_ms) track_mode = MODE_AFTER;
            if (is_steam) track_mode = MODE_STEAM;
         end
         MODE_AFTER: begin
            track_mode = tick.brew_detected ? MODE_BREW : MODE_SET;
            if (is_steam) track_mode = MODE_STEAM;
         end
         MODE_STEAM: begin
            if (!is_steam) track_mode = MODE_CHILL;
         end
         default: begin
            if (tick.heat_rate_rising && temp_i < tgt_i + int'(CHILL_BAND))
               track_mode = MODE_SET;
            if (is_steam) track_mode = MODE_STEAM;
         end
      endcase
      return track_mode;
   endfunction

   function automatic void apply_csr(input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_TARGET_TEMP:   model_cfg.target_temp   = data[TEMP_W-1:0];
         CSR_STEAM_TEMP:    model_cfg.steam_temp    = data[TEMP_W-1:0];
         CSR_COLD_MARGIN:   model_cfg.cold_margin   = data[TEMP_W-1:0];
         CSR_HOLD_MS:       model_cfg.hold_ms       = data[MS_W-1:0];
         CSR_BREW_LIMIT_MS: model_cfg.brew_limit_ms = data[MS_W-1:0];
         default: ;
      endcase
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_item_type tick;
            tick = pending_ticks.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.temperature      <= tick.temperature;
            req_bus.now_ms           <= tick.now_ms;
            req_bus.brew_detected    <= tick.brew_detected;
            req_bus.brew_time_ms     <= tick.brew_time_ms;
            req_bus.heat_rate_rising <= tick.heat_rate_rising;
            send_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: check responses, predict accepted requests, track csr writes
   always @(posedge clock) begin : monitor
      req_item_type seen;
      mode_type     want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_modes.size() == 0) begin
               note_failure($sformatf("unexpected response, mode %0d", rsp_bus.machine_mode));
            end else begin
               want = expected_modes.pop_front();
               if (rsp_bus.machine_mode !== want)
                  note_failure($sformatf("mode mismatch: expected %0d (%s) got %0d",
                                         want, want.name(), rsp_bus.machine_mode));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen = make_tick(req_bus.temperature, req_bus.now_ms, req_bus.brew_detected,
                             req_bus.brew_time_ms, req_bus.heat_rate_rising);
            expected_modes.push_back(advance_mode(seen));
         end
         if (csr_bus.valid && csr_bus.ready) apply_csr(csr_bus.index, csr_bus.data);
         // response back-pressure
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Nothing queued, nothing on the wire, nothing outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_bus.valid || expected_modes.size() != 0);
   endtask

   // Upper bits of the 12-bit registers are junk to exercise masking
   task automatic set_config(input logic [TEMP_W-1:0] tgt, input logic [TEMP_W-1:0] stm,
                             input logic [TEMP_W-1:0] margin, input logic [MS_W-1:0] hold,
                             input logic [MS_W-1:0] limit);
      write_csr(CSR_TARGET_TEMP, {(DATA_W - TEMP_W)'($urandom), tgt});
      write_csr(CSR_STEAM_TEMP, {(DATA_W - TEMP_W)'($urandom), stm});
      write_csr(CSR_COLD_MARGIN, {(DATA_W - TEMP_W)'($urandom), margin});
      write_csr(CSR_HOLD_MS, hold);
      write_csr(CSR_BREW_LIMIT_MS, limit);
      // unmapped indexes must be ignored
      for (int i = int'(CSR_BREW_LIMIT_MS) + 1; i < (1 << IDX_W); i++)
         write_csr(IDX_W'(i), DATA_W'($urandom));
   endtask

   // Random ticks: brew shots, steam trips and noise
   task automatic run_random(input int n_ticks);
      int issued;
      int n;
      int n2;
      int step;
      int bt;
      int last_bt;
      int tgt;
      int stm;
      issued = 0;
      while (issued < n_ticks) begin
         idle_on = $urandom_range(0, 3) != 0;
         tgt = int'(model_cfg.target_temp);
         stm = int'(model_cfg.steam_temp);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // brew shot, often crossing the brew limit
               n    = $urandom_range(2, 14);
               step = $urandom_range(1, 9000);
               if ($urandom_range(0, 1))
                  bt = int'(model_cfg.brew_limit_ms) - int'($urandom_range(0, 2 * step));
               else
                  bt = 1;
               last_bt = 1;
               for (int k = 0; k < n; k++) begin
                  if (bt < 1) bt = 1;
                  if (bt > (1 << MS_W) - 1) bt = (1 << MS_W) - 1;
                  last_bt = bt;
                  pending_ticks.push_back(make_tick(pick_temp(), next_stamp(), 1'b1,
                                                    MS_W'(bt), 1'($urandom)));
                  bt += step;
               end
               n2 = $urandom_range(1, 3);
               for (int k = 0; k < n2; k++)
                  pending_ticks.push_back(make_tick(pick_temp(), next_stamp(), 1'b0,
                                                    $urandom_range(0, 1) ? MS_W'(last_bt) : '0,
                                                    1'($urandom)));
               issued += n + n2;
            end
            5, 6: begin
               // heat up past steam, cool down, settle near setpoint
               n = $urandom_range(1, 4);
               for (int k = 0; k < n; k++)
                  pending_ticks.push_back(make_tick(
                     clamp_temp(stm - 10 + k * int'($urandom_range(3, 25))),
                     next_stamp(), 1'b0, '0, 1'b1));
               n2 = $urandom_range(1, 4);
               for (int k = 0; k < n2; k++)
                  pending_ticks.push_back(make_tick(
                     clamp_temp(stm - 1 - k * int'($urandom_range(5, 60))),
                     next_stamp(), 1'b0, '0, 1'b0));
               pending_ticks.push_back(make_tick(
                  clamp_temp(tgt + int'($urandom_range(0, 40)) - 8),
                  next_stamp(), 1'b0, '0, 1'b1));
               issued += n + n2 + 1;
            end
            default: begin
               n = $urandom_range(1, 5);
               for (int k = 0; k < n; k++)
                  pending_ticks.push_back(make_tick(
                     pick_temp(), STAMP_W'($urandom), 1'($urandom),
                     ($urandom_range(0, 2) == 0) ? '0 : MS_W'($urandom), 1'($urandom)));
               issued += n;
            end
         endcase
         // keep the queue short so idling changes track the sequences
         while (pending_ticks.size() > 4) @(negedge clock);
         // sender holds off until the tracker has fully drained
         if ($urandom_range(0, 15) == 0) wait_idle();
      end
      wait_idle();
   endtask

   // Stimulus
   initial begin
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.temperature      = '0;
      req_bus.now_ms           = '0;
      req_bus.brew_detected    = 1'b0;
      req_bus.brew_time_ms     = '0;
      req_bus.heat_rate_rising = 1'b0;
      rsp_bus.ready            = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = '0;
      csr_bus.data             = '0;
      fail_count               = 0;
      cycle_count              = 0;
      idle_on                  = 1'b1;
      stamp_ms                 = STAMP_W'($urandom);
      model_cfg.target_temp    = TARGET_TEMP_RST;
      model_cfg.steam_temp     = STEAM_TEMP_RST;
      model_cfg.cold_margin    = COLD_MARGIN_RST;
      model_cfg.hold_ms        = HOLD_MS_RST;
      model_cfg.brew_limit_ms  = BREW_LIMIT_MS_RST;
      track_mode               = MODE_INIT;
      track_waiting            = 1'b0;
      track_stamp              = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // steam above the cold ceiling so the ceiling itself can be reached
      write_csr(CSR_STEAM_TEMP, 16'd3000);

      // Directed walk through every mode from init
      pending_ticks.push_back(make_tick(12'd0,    32'd0,          1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd2400, 32'd50,         1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1472, 32'd100,        1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1471, 32'd200,        1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd2399, 32'hFFFF_F000,  1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1500, 32'h0000_1710,  1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1500, 32'hFFFF_FFFF,  1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1487, 32'd300,        1'b0, 16'd0,     1'b1));
      pending_ticks.push_back(make_tick(12'd1488, 32'd400,        1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd500,        1'b1, 16'd1,     1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd600,        1'b1, 16'd35000, 1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd700,        1'b1, 16'd35001, 1'b0));
      pending_ticks.push_back(make_tick(12'd2999, 32'd800,        1'b1, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd900,        1'b0, 16'd35001, 1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd1000,       1'b1, 16'hFFFF,  1'b0));
      pending_ticks.push_back(make_tick(12'd1480, 32'd1100,       1'b1, 16'hFFFF,  1'b0));
      pending_ticks.push_back(make_tick(12'd3000, 32'd1200,       1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'hFFF,  32'd1300,       1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd2999, 32'd1400,       1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1520, 32'd1500,       1'b0, 16'd0,     1'b1));
      pending_ticks.push_back(make_tick(12'd0,    32'd1600,       1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'd1519, 32'd1700,       1'b0, 16'd0,     1'b1));
      pending_ticks.push_back(make_tick(12'd3000, 32'd1800,       1'b0, 16'd1,     1'b0));
      pending_ticks.push_back(make_tick(12'd0,    32'd1900,       1'b0, 16'd0,     1'b0));
      pending_ticks.push_back(make_tick(12'hFFF,  32'd2000,       1'b1, 16'd0,     1'b1));
      wait_idle();

      run_random(250);

      // Register extremes, each register seeing both ends
      set_config('0, '1, '0, '0, '0);
      run_random(250);
      set_config('1, '0, '1, '1, '1);
      run_random(250);

      // Realistic random settings
      for (int p = 0; p < 2; p++) begin
         set_config(TEMP_W'($urandom_range(1200, 1700)), TEMP_W'($urandom_range(1500, 4095)),
                    TEMP_W'($urandom), MS_W'($urandom), MS_W'($urandom));
         run_random(250);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_modes.size() != 0)
         note_failure($sformatf("%0d responses never arrived", expected_modes.size()));
      if (fail_count == 0) begin
         $display("heater_mode_tracker_tb passed");
      end else begin
         $display("heater_mode_tracker_tb failed");
      end
      $finish;
   end

endmodule
